### hdl/ddo_pkg.sv
// ----------------------------------------------------------------------------
// ddo_pkg
// Shared types, constants and helper functions of the odometry datapath.
// ----------------------------------------------------------------------------
package ddo_pkg;

  localparam int unsigned CFG_AW       = 3;
  localparam int unsigned MUL_W        = 33;
  localparam int unsigned PROD_W       = 66;
  localparam int unsigned DIV_NW       = 64;
  localparam int unsigned DIV_DW       = 48;
  localparam int unsigned CORDIC_STEPS = 16;
  localparam int unsigned CORDIC_XW    = 34;
  localparam int unsigned CORDIC_ZW    = 21;
  localparam int unsigned TRIG_W       = 20;
  localparam int unsigned HEAD_W       = 17;

  localparam logic signed [CORDIC_XW-1:0] CORDIC_GAIN  = 34'sd652032874;
  localparam logic signed [HEAD_W-1:0]    HALF_TURN    = 17'sd25736;
  localparam logic signed [HEAD_W-1:0]    FULL_TURN    = 17'sd51472;
  localparam logic signed [HEAD_W-1:0]    QUARTER_TURN = 17'sd12868;
  localparam logic signed [MUL_W-1:0]     PULSE_SCALE  = 33'sd65536000;
  localparam logic [DIV_DW-1:0]           MS_PER_S     = 48'd1000;
  localparam logic signed [PROD_W-1:0]    SAT_MAX      = 66'sh0_7FFF_FFFF;
  localparam logic signed [PROD_W-1:0]    SAT_MIN      = -66'sh0_8000_0000;

  typedef enum logic [CFG_AW-1:0] {
    REG_PPT     = 3'd0,
    REG_SCALE   = 3'd1,
    REG_TRACK   = 3'd2,
    REG_OFFSET  = 3'd3,
    REG_START_X = 3'd4,
    REG_START_Y = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] num;
    logic [DIV_DW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_NW-1:0] quo;
  } div_rsp_t;

  typedef struct packed {
    logic                     busy;
    logic signed [TRIG_W-1:0] cos;
    logic signed [TRIG_W-1:0] sin;
  } trig_rsp_t;

  function automatic logic signed [CORDIC_ZW-1:0] atan_q16(input logic [3:0] idx);
    logic signed [CORDIC_ZW-1:0] r;
    case (idx)
      4'd0:    r = 21'sd51472;
      4'd1:    r = 21'sd30385;
      4'd2:    r = 21'sd16055;
      4'd3:    r = 21'sd8150;
      4'd4:    r = 21'sd4091;
      4'd5:    r = 21'sd2047;
      4'd6:    r = 21'sd1024;
      4'd7:    r = 21'sd512;
      4'd8:    r = 21'sd256;
      4'd9:    r = 21'sd128;
      4'd10:   r = 21'sd64;
      4'd11:   r = 21'sd32;
      4'd12:   r = 21'sd16;
      4'd13:   r = 21'sd8;
      4'd14:   r = 21'sd4;
      default: r = 21'sd2;
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] v);
    logic signed [31:0] r;
    if (v > SAT_MAX) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < SAT_MIN) begin
      r = -32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [PROD_W-1:0] apply_sign(input logic [DIV_NW-1:0] q,
                                                          input logic neg);
    logic signed [PROD_W-1:0] qs;
    qs = $signed({2'b00, q});
    return neg ? -qs : qs;
  endfunction

endpackage

### hdl/differential_drive_odometry.sv
// ----------------------------------------------------------------------------
// differential_drive_odometry
// Dead-reckoning odometry for a two-wheel robot in Q16.16 fixed point.
// ----------------------------------------------------------------------------
// Input beats (func, pulse deltas, timestamp, yaw) enter on in_valid_i while
// in_stall_o is low; each beat yields exactly one result beat on out_valid_o,
// held until out_stall_i is low. The user must write registers through
// cfg_we_i, cfg_addr_i and cfg_wdata_i only while the block is idle; the
// block itself does not enforce it. A restart beat or one with zero elapsed time
// goes straight to the done state. An update beat makes five passes through
// the shared divider (two wheel rates, angular speed and two position steps),
// with the shared multiplier working between passes and the 16-step CORDIC
// running alongside the angular-speed pass. One beat is in work at a time and
// in_stall_o stays high until its result is handed to the output register.
// A stalled result holds in the output register; the next beat may be taken
// meanwhile and waits at its end until the register is free.
// Reset loads the register defaults, clears position, speeds and stored time,
// and leaves the block idle with no result pending.
// ----------------------------------------------------------------------------
module differential_drive_odometry (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [ddo_pkg::CFG_AW-1:0]       cfg_addr_i,
  input  logic [31:0]                      cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             func_i,
  input  logic signed [15:0]               left_pulses_i,
  input  logic signed [15:0]               right_pulses_i,
  input  logic [31:0]                      now_ms_i,
  input  logic signed [15:0]               imu_yaw_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [31:0]               pos_x_o,
  output logic signed [31:0]               pos_y_o,
  output logic signed [16:0]               heading_o,
  output logic signed [31:0]               linear_speed_o,
  output logic signed [31:0]               angular_speed_o,
  output logic                             zero_interval_o
);
  import ddo_pkg::*;

  typedef enum logic [14:0] {
    ST_IDLE  = 15'b000000000000001,
    ST_DEN   = 15'b000000000000010,
    ST_NUM   = 15'b000000000000100,
    ST_DIVW  = 15'b000000000001000,
    ST_WAITW = 15'b000000000010000,
    ST_SCALE = 15'b000000000100000,
    ST_WHEEL = 15'b000000001000000,
    ST_ANG   = 15'b000000010000000,
    ST_WAITA = 15'b000000100000000,
    ST_STEP  = 15'b000001000000000,
    ST_MAG   = 15'b000010000000000,
    ST_DT    = 15'b000100000000000,
    ST_DIVP  = 15'b001000000000000,
    ST_WAITP = 15'b010000000000000,
    ST_DONE  = 15'b100000000000000
  } state_e;

  state_e state_q;

  logic [15:0]        ppt_q;
  logic [30:0]        scale_q;
  logic [30:0]        track_q;
  logic signed [15:0] offset_q;
  logic signed [31:0] sx_q;
  logic signed [31:0] sy_q;

  logic signed [31:0] last_x_q;
  logic signed [31:0] last_y_q;
  logic signed [31:0] prev_lin_q;
  logic signed [31:0] prev_ang_q;
  logic [31:0]        last_time_q;

  logic signed [HEAD_W-1:0] head_q;
  logic [31:0]        now_q;
  logic [31:0]        dt_q;
  logic signed [15:0] lp_q;
  logic signed [15:0] rp_q;
  logic               flag_q;
  logic [DIV_DW-1:0]  den_q;
  logic               neg_q;
  logic               mag_neg_q;
  logic [31:0]        mag_q;
  logic signed [31:0] rps_q;
  logic signed [31:0] ls_q;
  logic signed [31:0] rs_q;
  logic signed [31:0] lin_q;
  logic signed [31:0] ang_q;
  logic signed [31:0] mean_q;
  logic               wsel_q;
  logic               asel_q;

  logic               out_valid_q;
  logic signed [31:0] out_x_q;
  logic signed [31:0] out_y_q;
  logic signed [16:0] out_head_q;
  logic signed [31:0] out_lin_q;
  logic signed [31:0] out_ang_q;
  logic               out_flag_q;

  logic [15:0]        ppt_eff;
  logic [30:0]        tw_eff;
  logic [31:0]        dt_in;
  logic signed [HEAD_W-1:0] head_in;
  logic               accept;
  logic signed [MUL_W-1:0]  mul_a;
  logic signed [MUL_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] prod;
  div_req_t           div_req;
  div_rsp_t           div_rsp;
  trig_rsp_t          trig;
  logic               trig_start;
  logic signed [32:0] sum_lr;
  logic signed [32:0] diff_lr;
  logic [32:0]        abs_lr;
  logic signed [32:0] mean_sum;
  logic signed [PROD_W-1:0] step;
  logic signed [PROD_W-1:0] step_abs;
  logic signed [PROD_W-1:0] prod_abs;
  logic signed [PROD_W-1:0] pos_sum;

  assign ppt_eff = (ppt_q == '0) ? 16'd1 : ppt_q;
  assign tw_eff  = (track_q == '0) ? 31'd1 : track_q;
  assign dt_in   = now_ms_i - last_time_q;
  assign head_in = HEAD_W'(imu_yaw_i) - HEAD_W'(offset_q);
  assign accept  = in_valid_i && (state_q == ST_IDLE);

  assign sum_lr   = 33'(ls_q) + 33'(rs_q);
  assign diff_lr  = 33'(rs_q) - 33'(ls_q);
  assign abs_lr   = diff_lr[32] ? 33'(-diff_lr) : 33'(diff_lr);
  assign mean_sum = 33'(lin_q) + 33'(prev_lin_q);
  assign step     = prod >>> 16;
  assign step_abs = step[PROD_W-1] ? -step : step;
  assign prod_abs = prod[PROD_W-1] ? -prod : prod;
  assign pos_sum  = PROD_W'(asel_q ? last_y_q : last_x_q)
                    + apply_sign(div_rsp.quo, neg_q);
  assign trig_start = (state_q == ST_ANG);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_DEN: begin
        mul_a = $signed({17'd0, ppt_eff});
        mul_b = $signed({1'b0, dt_q});
      end
      ST_NUM: begin
        mul_a = MUL_W'(wsel_q ? rp_q : lp_q);
        mul_b = PULSE_SCALE;
      end
      ST_SCALE: begin
        mul_a = MUL_W'(rps_q);
        mul_b = $signed({2'b00, scale_q});
      end
      ST_STEP: begin
        mul_a = MUL_W'(mean_q);
        mul_b = MUL_W'(asel_q ? trig.sin : trig.cos);
      end
      ST_DT: begin
        mul_a = $signed({1'b0, mag_q});
        mul_b = $signed({1'b0, dt_q});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    div_req = '0;
    case (state_q)
      ST_DIVW: begin
        div_req.start = 1'b1;
        div_req.num   = prod_abs[DIV_NW-1:0];
        div_req.den   = den_q;
      end
      ST_ANG: begin
        div_req.start = 1'b1;
        div_req.num   = {15'd0, abs_lr, 16'd0};
        div_req.den   = DIV_DW'(tw_eff);
      end
      ST_DIVP: begin
        div_req.start = 1'b1;
        div_req.num   = prod[DIV_NW-1:0];
        div_req.den   = MS_PER_S;
      end
      default: div_req = '0;
    endcase
  end

  ddo_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  ddo_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  ddo_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (trig_start),
    .head_i  (head_q),
    .rsp_o   (trig)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ppt_q       <= 16'd1024;
      scale_q     <= 31'd10294;
      track_q     <= 31'd19661;
      offset_q    <= '0;
      sx_q        <= '0;
      sy_q        <= '0;
      last_x_q    <= '0;
      last_y_q    <= '0;
      prev_lin_q  <= '0;
      prev_ang_q  <= '0;
      last_time_q <= '0;
      out_valid_q <= 1'b0;
      wsel_q      <= 1'b0;
      asel_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          REG_PPT:     ppt_q    <= cfg_wdata_i[15:0];
          REG_SCALE:   scale_q  <= cfg_wdata_i[30:0];
          REG_TRACK:   track_q  <= cfg_wdata_i[30:0];
          REG_OFFSET:  offset_q <= cfg_wdata_i[15:0];
          REG_START_X: sx_q     <= cfg_wdata_i;
          REG_START_Y: sy_q     <= cfg_wdata_i;
          default: ;
        endcase
      end

      if (out_valid_q && !out_stall_i && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            wsel_q <= 1'b0;
            asel_q <= 1'b0;
            if (func_i) begin
              last_x_q    <= sx_q;
              last_y_q    <= sy_q;
              prev_lin_q  <= '0;
              prev_ang_q  <= '0;
              last_time_q <= '0;
              state_q     <= ST_DONE;
            end else if (dt_in == '0) begin
              prev_lin_q  <= '0;
              prev_ang_q  <= '0;
              last_time_q <= now_ms_i;
              state_q     <= ST_DONE;
            end else begin
              state_q <= ST_DEN;
            end
          end
        end
        ST_DEN:   state_q <= ST_NUM;
        ST_NUM:   state_q <= ST_DIVW;
        ST_DIVW:  state_q <= ST_WAITW;
        ST_WAITW: begin
          if (div_rsp.done) begin
            state_q <= ST_SCALE;
          end
        end
        ST_SCALE: state_q <= ST_WHEEL;
        ST_WHEEL: begin
          if (wsel_q) begin
            state_q <= ST_ANG;
          end else begin
            wsel_q  <= 1'b1;
            state_q <= ST_NUM;
          end
        end
        ST_ANG:   state_q <= ST_WAITA;
        ST_WAITA: begin
          if (div_rsp.done) begin
            state_q <= ST_STEP;
          end
        end
        ST_STEP: begin
          if (!trig.busy) begin
            state_q <= ST_MAG;
          end
        end
        ST_MAG:   state_q <= ST_DT;
        ST_DT:    state_q <= ST_DIVP;
        ST_DIVP:  state_q <= ST_WAITP;
        ST_WAITP: begin
          if (div_rsp.done) begin
            if (asel_q) begin
              last_y_q    <= sat32(pos_sum);
              prev_lin_q  <= lin_q;
              prev_ang_q  <= ang_q;
              last_time_q <= now_q;
              state_q     <= ST_DONE;
            end else begin
              last_x_q <= sat32(pos_sum);
              asel_q   <= 1'b1;
              state_q  <= ST_STEP;
            end
          end
        end
        ST_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          head_q <= head_in;
          now_q  <= now_ms_i;
          dt_q   <= dt_in;
          lp_q   <= left_pulses_i;
          rp_q   <= right_pulses_i;
          flag_q <= !func_i && (dt_in == '0);
        end
      end
      ST_NUM: begin
        if (!wsel_q) begin
          den_q <= prod[DIV_DW-1:0];
        end
      end
      ST_DIVW: neg_q <= prod[PROD_W-1];
      ST_WAITW: begin
        if (div_rsp.done) begin
          rps_q <= sat32(apply_sign(div_rsp.quo, neg_q));
        end
      end
      ST_WHEEL: begin
        if (wsel_q) begin
          rs_q <= sat32(step);
        end else begin
          ls_q <= sat32(step);
        end
      end
      ST_ANG: begin
        lin_q <= sum_lr[32:1];
        neg_q <= diff_lr[32];
      end
      ST_WAITA: begin
        if (div_rsp.done) begin
          ang_q  <= sat32(apply_sign(div_rsp.quo, neg_q));
          mean_q <= mean_sum[32:1];
        end
      end
      ST_MAG: begin
        mag_neg_q <= prod[PROD_W-1];
        mag_q     <= step_abs[31:0];
      end
      ST_DIVP: neg_q <= mag_neg_q;
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_x_q    <= last_x_q;
          out_y_q    <= last_y_q;
          out_head_q <= head_q;
          out_lin_q  <= prev_lin_q;
          out_ang_q  <= prev_ang_q;
          out_flag_q <= flag_q;
        end
      end
      default: ;
    endcase
  end

  assign in_stall_o      = (state_q != ST_IDLE);
  assign out_valid_o     = out_valid_q;
  assign pos_x_o         = out_x_q;
  assign pos_y_o         = out_y_q;
  assign heading_o       = out_head_q;
  assign linear_speed_o  = out_lin_q;
  assign angular_speed_o = out_ang_q;
  assign zero_interval_o = out_flag_q;

endmodule

### hdl/ddo_mul.sv
// ----------------------------------------------------------------------------
// ddo_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module ddo_mul (
  input  logic                                clk_i,
  input  logic signed [ddo_pkg::MUL_W-1:0]    a_i,
  input  logic signed [ddo_pkg::MUL_W-1:0]    b_i,
  output logic signed [ddo_pkg::PROD_W-1:0]   prod_o
);
  import ddo_pkg::*;

  logic signed [PROD_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= PROD_W'(a_i) * PROD_W'(b_i);
  end

  assign prod_o = prod_q;

endmodule

### hdl/ddo_div.sv
// ----------------------------------------------------------------------------
// ddo_div
// Restoring divider on magnitudes, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ddo_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ddo_pkg::div_req_t  req_i,
  output ddo_pkg::div_rsp_t  rsp_o
);
  import ddo_pkg::*;

  localparam int unsigned CNT_W = $clog2(DIV_NW);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_NW - 1);

  logic [DIV_NW-1:0] quo_q;
  logic [DIV_DW-1:0] rem_q;
  logic [DIV_DW-1:0] den_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              busy_q;
  logic              done_q;
  logic [DIV_DW:0]   rem_sh;
  logic [DIV_DW+1:0] diff;
  logic              borrow;

  assign rem_sh = {rem_q, quo_q[DIV_NW-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, den_q};
  assign borrow = diff[DIV_DW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CNT_LAST);
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_LAST) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.num;
      rem_q <= '0;
      den_q <= req_i.den;
    end else if (busy_q) begin
      rem_q <= borrow ? rem_sh[DIV_DW-1:0] : diff[DIV_DW-1:0];
      quo_q <= {quo_q[DIV_NW-2:0], ~borrow};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

endmodule

### hdl/ddo_cordic.sv
// ----------------------------------------------------------------------------
// ddo_cordic
// Rotation-mode CORDIC, one step per cycle, giving cosine and sine of heading.
// ----------------------------------------------------------------------------
module ddo_cordic (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic signed [ddo_pkg::HEAD_W-1:0] head_i,
  output ddo_pkg::trig_rsp_t                rsp_o
);
  import ddo_pkg::*;

  localparam int unsigned CNT_W = $clog2(CORDIC_STEPS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CORDIC_STEPS - 1);

  logic signed [CORDIC_XW-1:0] x_q;
  logic signed [CORDIC_XW-1:0] y_q;
  logic signed [CORDIC_ZW-1:0] z_q;
  logic                        neg_q;
  logic [CNT_W-1:0]            cnt_q;
  logic                        busy_q;
  logic signed [HEAD_W-1:0]    h_wrap;
  logic signed [HEAD_W-1:0]    h_fold;
  logic                        h_neg;
  logic signed [CORDIC_XW-1:0] sh_x;
  logic signed [CORDIC_XW-1:0] sh_y;
  logic signed [CORDIC_XW-1:0] x_sc;
  logic signed [CORDIC_XW-1:0] y_sc;
  logic signed [TRIG_W-1:0]    c_raw;
  logic signed [TRIG_W-1:0]    s_raw;

  always_comb begin
    if (head_i > HALF_TURN) begin
      h_wrap = head_i - FULL_TURN;
    end else if (head_i < -HALF_TURN) begin
      h_wrap = head_i + FULL_TURN;
    end else begin
      h_wrap = head_i;
    end
    h_neg = 1'b1;
    if (h_wrap > QUARTER_TURN) begin
      h_fold = h_wrap - HALF_TURN;
    end else if (h_wrap < -QUARTER_TURN) begin
      h_fold = h_wrap + HALF_TURN;
    end else begin
      h_fold = h_wrap;
      h_neg  = 1'b0;
    end
  end

  assign sh_x = x_q >>> cnt_q;
  assign sh_y = y_q >>> cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CNT_LAST) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q   <= CORDIC_GAIN;
      y_q   <= '0;
      z_q   <= CORDIC_ZW'(h_fold) <<< 3;
      neg_q <= h_neg;
    end else if (busy_q) begin
      if (z_q >= 0) begin
        x_q <= x_q - sh_y;
        y_q <= y_q + sh_x;
        z_q <= z_q - atan_q16(cnt_q);
      end else begin
        x_q <= x_q + sh_y;
        y_q <= y_q - sh_x;
        z_q <= z_q + atan_q16(cnt_q);
      end
    end
  end

  assign x_sc  = x_q >>> 14;
  assign y_sc  = y_q >>> 14;
  assign c_raw = x_sc[TRIG_W-1:0];
  assign s_raw = y_sc[TRIG_W-1:0];

  assign rsp_o.busy = busy_q;
  assign rsp_o.cos  = neg_q ? -c_raw : c_raw;
  assign rsp_o.sin  = neg_q ? -s_raw : s_raw;

endmodule

### hdl/ddo_checker.sv
// ----------------------------------------------------------------------------
// ddo_checker
// Port-level checks of the odometry block, bound to the top level.
// ----------------------------------------------------------------------------
module ddo_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_o,
  input  logic        out_valid_o,
  input  logic        out_stall_i,
  input  logic [31:0] pos_x_o,
  input  logic [31:0] pos_y_o,
  input  logic [31:0] linear_speed_o,
  input  logic [31:0] angular_speed_o,
  input  logic        zero_interval_o
);

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("block took a beat without going busy");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(pos_x_o) && $stable(pos_y_o))
    else $error("stalled result changed");

  a_zero_speeds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && zero_interval_o |-> linear_speed_o == 32'd0 && angular_speed_o == 32'd0)
    else $error("zero interval with nonzero speed");

  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without a beat in work");

endmodule

bind differential_drive_odometry ddo_checker u_ddo_checker (.*);
